@@ design/nstm_pkg.sv @@
package nstm_pkg;

  localparam int NOTE_W    = 7;
  localparam int NOTES     = 8;
  localparam int LEN_W     = 4;
  localparam int CFG_W     = 56;
  localparam int CFG_IDX_W = 3;
  localparam int MAX_SLOTS = 3;
  localparam int COUNT_W   = 2;
  localparam int INDEX_W   = 2;
  localparam int LENS_W    = LEN_W * MAX_SLOTS;

  // Configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_TEMPLATE_COUNT   = 3'd0,
    CFG_TEMPLATE_LENGTHS = 3'd1,
    CFG_NOTES_A          = 3'd2,
    CFG_NOTES_B          = 3'd3,
    CFG_NOTES_C          = 3'd4
  } cfg_index_t;

  typedef logic [NOTE_W-1:0] note_t;

  typedef struct packed {
    logic               match_found;
    logic [INDEX_W-1:0] template_index;
  } result_t;

  // True when two notes differ by at most one bin
  function automatic logic note_close(input note_t a, input note_t b);
    logic [NOTE_W:0] d;
    d = {1'b0, a} - {1'b0, b};
    return (d == '0) || (d == (NOTE_W+1)'(1)) || (d == '1);
  endfunction

endpackage

@@ design/nstm_note_if.sv @@
interface nstm_note_if
  import nstm_pkg::*;
();
  logic  valid;
  logic  ready;
  note_t note_value;

  modport source (output valid, output note_value, input ready);
  modport sink   (input valid, input note_value, output ready);
endinterface

@@ design/nstm_match_if.sv @@
interface nstm_match_if
  import nstm_pkg::*;
();
  logic               valid;
  logic               ready;
  logic               match_found;
  logic [INDEX_W-1:0] template_index;

  modport source (output valid, output match_found, output template_index, input ready);
  modport sink   (input valid, input match_found, input template_index, output ready);
endinterface

@@ design/nstm_history.sv @@
module nstm_history
  import nstm_pkg::*;
#(
  parameter int HISTORY_DEPTH = 8
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             shift,
  input  note_t                            note_value,
  output logic [HISTORY_DEPTH-1:0][NOTE_W-1:0] view
);

  logic [HISTORY_DEPTH-1:0][NOTE_W-1:0] hist;

  // History as it stands once the incoming note is shifted in; entry 0 is newest
  always_comb begin
    view[0] = note_value;
    for (int k = 1; k < HISTORY_DEPTH; k++) begin
      view[k] = hist[k-1];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      hist <= '0;
    end else if (shift) begin
      hist <= view;
    end
  end

endmodule

@@ design/nstm_slot_match.sv @@
module nstm_slot_match
  import nstm_pkg::*;
#(
  parameter int HISTORY_DEPTH = 8
) (
  input  logic [HISTORY_DEPTH-1:0][NOTE_W-1:0] view,
  input  logic [CFG_W-1:0]                     notes,
  input  logic [LEN_W-1:0]                     len,
  output logic                                 match
);

  logic [NOTES-1:0][HISTORY_DEPTH-1:0] ok;
  logic [NOTES:0]                      len_ok;
  logic [LEN_W-1:0]                    len_sat;

  // Every template note against every history entry
  for (genvar j = 0; j < NOTES; j++) begin : g_note
    for (genvar a = 0; a < HISTORY_DEPTH; a++) begin : g_age
      assign ok[j][a] = note_close(view[a], notes[NOTE_W*j +: NOTE_W]);
    end
  end

  // Match result for each possible length; last note aligns with the newest entry
  always_comb begin
    for (int l = 0; l <= NOTES; l++) begin
      len_ok[l] = 1'b1;
      for (int j = 0; j < l; j++) begin
        len_ok[l] = len_ok[l] & ok[j][(l - 1 - j) % HISTORY_DEPTH];
      end
    end
  end

  // Lengths above eight saturate
  assign len_sat = (len > LEN_W'(NOTES)) ? LEN_W'(NOTES) : len;
  assign match   = len_ok[len_sat];

endmodule

@@ design/nstm_out_buf.sv @@
module nstm_out_buf
  import nstm_pkg::*;
(
  input  logic         clk,
  input  logic         rst,
  input  logic         push,
  input  result_t      push_data,
  output logic         can_push,
  nstm_match_if.source match_out
);

  logic    out_valid;
  result_t out_data;
  logic    skid_valid;
  result_t skid_data;
  logic    pop;

  assign pop      = out_valid && match_out.ready;
  assign can_push = !skid_valid;

  assign match_out.valid          = out_valid;
  assign match_out.match_found    = out_data.match_found;
  assign match_out.template_index = out_data.template_index;

  // Control: output stage plus one skid entry
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else begin
      if (pop) begin
        if (skid_valid) begin
          skid_valid <= 1'b0;
        end else if (!push) begin
          out_valid <= 1'b0;
        end
      end
      if (push) begin
        if (!out_valid || pop) begin
          out_valid <= 1'b1;
        end else begin
          skid_valid <= 1'b1;
        end
      end
    end
  end

  // Payload
  always_ff @(posedge clk) begin
    if (pop && skid_valid) begin
      out_data <= skid_data;
    end else if (push && (!out_valid || pop)) begin
      out_data <= push_data;
    end
    if (push && out_valid && !pop) begin
      skid_data <= push_data;
    end
  end

  property p_skid_needs_out;
    @(posedge clk) disable iff (rst) skid_valid |-> out_valid;
  endproperty
  a_skid_needs_out: assert property (p_skid_needs_out)
    else $error("skid entry held while output stage empty");

  property p_stall_fills_skid;
    @(posedge clk) disable iff (rst) (push && out_valid && !match_out.ready) |=> skid_valid;
  endproperty
  a_stall_fills_skid: assert property (p_stall_fills_skid)
    else $error("item pushed during stall not kept in skid entry");

  property p_skid_drains;
    @(posedge clk) disable iff (rst) (skid_valid && pop) |=> (out_valid && !skid_valid);
  endproperty
  a_skid_drains: assert property (p_skid_drains)
    else $error("skid entry not moved to output after pop");

endmodule

@@ design/note_sequence_template_matcher_top.sv @@
// Note sequence template matcher.
// note_in carries one detected note per item; match_out returns one result
// per item: match_found and the first matching template slot.
// Configuration is written through cfg_we/cfg_index/cfg_data; the user
// must write it only while idle, which the block does not enforce:
// index 0 template count, 1 packed lengths, 2..4 notes of slots 0..2.
// Each accepted note is shifted into the history and all enabled slots
// are compared in parallel against the updated history in the same cycle;
// the result is registered in the output stage. Throughput: one item per
// cycle while note_in.ready is high, set by the single compare stage
// feeding the output register. If the receiver stalls, one further result is
// held in a skid entry; note_in.ready drops only while that entry is occupied.
// Reset clears the history to zero notes, all configuration registers to
// zero and empties the output stage.
module note_sequence_template_matcher_top
  import nstm_pkg::*;
#(
  parameter int HISTORY_DEPTH  = 8,
  parameter int TEMPLATE_SLOTS = 3
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_data,
  nstm_note_if.sink            note_in,
  nstm_match_if.source         match_out
);

  logic [COUNT_W-1:0]                    template_count;
  logic [LENS_W-1:0]                     template_lengths;
  logic [MAX_SLOTS-1:0][CFG_W-1:0]       template_notes;
  logic [HISTORY_DEPTH-1:0][NOTE_W-1:0]  view;
  logic [TEMPLATE_SLOTS-1:0]             slot_match;
  logic [COUNT_W-1:0]                    count_eff;
  logic                                  accept;
  logic                                  can_push;
  result_t                               result;

  assign accept        = note_in.valid && can_push;
  assign note_in.ready = can_push;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      template_count   <= '0;
      template_lengths <= '0;
      template_notes   <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_TEMPLATE_COUNT:   template_count    <= cfg_data[COUNT_W-1:0];
        CFG_TEMPLATE_LENGTHS: template_lengths  <= cfg_data[LENS_W-1:0];
        CFG_NOTES_A:          template_notes[0] <= cfg_data;
        CFG_NOTES_B:          template_notes[1] <= cfg_data;
        CFG_NOTES_C:          template_notes[2] <= cfg_data;
        default: ;
      endcase
    end
  end

  nstm_history #(.HISTORY_DEPTH(HISTORY_DEPTH)) u_history (
    .clk        (clk),
    .rst        (rst),
    .shift      (accept),
    .note_value (note_in.note_value),
    .view       (view)
  );

  for (genvar s = 0; s < TEMPLATE_SLOTS; s++) begin : g_slot
    nstm_slot_match #(.HISTORY_DEPTH(HISTORY_DEPTH)) u_slot (
      .view  (view),
      .notes (template_notes[s]),
      .len   (template_lengths[LEN_W*s +: LEN_W]),
      .match (slot_match[s])
    );
  end

  // Only the first TEMPLATE_SLOTS slots can be searched
  assign count_eff = (template_count > COUNT_W'(TEMPLATE_SLOTS)) ?
                     COUNT_W'(TEMPLATE_SLOTS) : template_count;

  // First matching slot in order wins
  always_comb begin
    result = '0;
    for (int s = TEMPLATE_SLOTS - 1; s >= 0; s--) begin
      if (slot_match[s] && (COUNT_W'(s) < count_eff)) begin
        result.match_found    = 1'b1;
        result.template_index = INDEX_W'(s);
      end
    end
  end

  nstm_out_buf u_out_buf (
    .clk       (clk),
    .rst       (rst),
    .push      (accept),
    .push_data (result),
    .can_push  (can_push),
    .match_out (match_out)
  );

  property p_no_match_index_zero;
    @(posedge clk) disable iff (rst)
      (match_out.valid && !match_out.match_found) |-> (match_out.template_index == '0);
  endproperty
  a_no_match_index_zero: assert property (p_no_match_index_zero)
    else $error("template index nonzero without a match");

  property p_index_in_range;
    @(posedge clk) disable iff (rst)
      (match_out.valid && match_out.match_found) |->
        (match_out.template_index < INDEX_W'(TEMPLATE_SLOTS));
  endproperty
  a_index_in_range: assert property (p_index_in_range)
    else $error("reported slot beyond available slots");

  property p_count_zero_no_match;
    @(posedge clk) disable iff (rst)
      (accept && (template_count == '0)) |=> (match_out.valid && !match_out.match_found)
        || $past(match_out.valid && !match_out.ready);
  endproperty
  a_count_zero_no_match: assert property (p_count_zero_no_match)
    else $error("match reported with no slots searched");

endmodule

@@ test/nstm_match_monitor.sv @@
module nstm_match_monitor
  import nstm_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_data,
  nstm_note_if                 note_in,
  nstm_match_if                match_out,
  output int                   pending,
  output int                   fail_count
);
  timeunit 1ns;
  timeprecision 1ps;

  // Shadow copy of the configuration
  logic [COUNT_W-1:0] slots_used;
  logic [LENS_W-1:0]  slot_lengths;
  logic [CFG_W-1:0]   slot_notes [MAX_SLOTS];

  // Recent notes, entry 0 is the newest
  note_t recent_notes [NOTES];

  result_t expected_matches [$];
  result_t want;
  int      result_seq = 0;

  task automatic report_error(input string what);
    $display("[%0t] mismatch: %s", $time, what);
    fail_count++;
  endtask

  // One slot matches when each of its notes is within one bin of the history,
  // oldest note first, the last template note against the newest entry.
  function automatic bit slot_hits(input int slot);
    int len;
    int d;
    len = int'(slot_lengths[slot*LEN_W +: LEN_W]);
    if (len > NOTES) len = NOTES;
    for (int j = 0; j < len; j++) begin
      d = int'(recent_notes[(len - 1 - j) % NOTES]) -
          int'(slot_notes[slot][j*NOTE_W +: NOTE_W]);
      if (d > 1 || d < -1) return 1'b0;
    end
    return 1'b1;
  endfunction

  // First matching slot in order, or no match
  function automatic result_t first_matching_slot();
    result_t r;
    int      n;
    r = '0;
    n = int'(slots_used);
    if (n > MAX_SLOTS) n = MAX_SLOTS;
    for (int s = 0; s < n; s++) begin
      if (slot_hits(s)) begin
        r.match_found    = 1'b1;
        r.template_index = INDEX_W'(s);
        return r;
      end
    end
    return r;
  endfunction

  always @(posedge clk) begin
    if (rst) begin
      slots_used   = '0;
      slot_lengths = '0;
      for (int s = 0; s < MAX_SLOTS; s++) slot_notes[s] = '0;
      for (int i = 0; i < NOTES; i++) recent_notes[i] = '0;
      expected_matches.delete();
      pending <= 0;
    end else begin
      // Configuration writes
      if (cfg_we) begin
        case (cfg_index_t'(cfg_index))
          CFG_TEMPLATE_COUNT:   slots_used   = cfg_data[COUNT_W-1:0];
          CFG_TEMPLATE_LENGTHS: slot_lengths = cfg_data[LENS_W-1:0];
          CFG_NOTES_A:          slot_notes[0] = cfg_data;
          CFG_NOTES_B:          slot_notes[1] = cfg_data;
          CFG_NOTES_C:          slot_notes[2] = cfg_data;
          default: ;
        endcase
      end

      // Accepted note: shift history and predict
      if (note_in.valid && note_in.ready) begin
        for (int i = NOTES - 1; i > 0; i--) recent_notes[i] = recent_notes[i-1];
        recent_notes[0] = note_in.note_value;
        expected_matches.push_back(first_matching_slot());
      end

      // Accepted result: compare with the oldest prediction
      if (match_out.valid && match_out.ready) begin
        if (expected_matches.size() == 0) begin
          report_error($sformatf("result %0d arrived with no note outstanding", result_seq));
        end else begin
          want = expected_matches.pop_front();
          if (match_out.match_found !== want.match_found)
            report_error($sformatf("result %0d: match_found %b, expected %b",
                                   result_seq, match_out.match_found, want.match_found));
          if (match_out.template_index !== want.template_index)
            report_error($sformatf("result %0d: template_index %0d, expected %0d",
                                   result_seq, match_out.template_index,
                                   want.template_index));
        end
        result_seq++;
      end

      pending <= expected_matches.size();
    end
  end

endmodule

@@ test/tb_note_sequence_template_matcher_top.sv @@
module tb_note_sequence_template_matcher_top;
  timeunit 1ns;
  timeprecision 1ps;
  import nstm_pkg::*;

  localparam int STALL_LIMIT  = 2000;
  localparam int HOLD_CYCLES  = 64;
  localparam int PHASES       = 9;
  localparam int PHASE_NOTES  = 105;

  logic                 clk = 1'b0;
  logic                 rst;
  logic                 cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_W-1:0]     cfg_data;

  nstm_note_if  note_ch ();
  nstm_match_if match_ch ();

  int pending;
  int fail_count;
  int quiet_cycles = 0;

  // Sender burst state
  int notes_sent = 0;
  int burst_left = 1;
  bit steady     = 1'b0;
  bit hold_req   = 1'b0;

  // Templates currently loaded, used to build matching sequences
  logic [LENS_W-1:0] cur_lens;
  logic [CFG_W-1:0]  cur_notes [MAX_SLOTS];

  note_sequence_template_matcher_top dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .note_in   (note_ch),
    .match_out (match_ch)
  );

  nstm_match_monitor match_mon (
    .clk        (clk),
    .rst        (rst),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .note_in    (note_ch),
    .match_out  (match_ch),
    .pending    (pending),
    .fail_count (fail_count)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Watchdog: no item moving on either channel for too long
  always @(posedge clk) begin
    if (rst || (note_ch.valid && note_ch.ready) || (match_ch.valid && match_ch.ready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("note_sequence_template_matcher_top regression: fail");
      $finish;
    end
  end

  // Receiver: stall pattern in segments, plus one long hold-off on request
  initial begin : receiver
    int mode;
    int seg;
    match_ch.ready <= 1'b0;
    forever begin
      mode = $urandom_range(0, 3);
      seg  = $urandom_range(10, 80);
      repeat (seg) begin
        @(posedge clk);
        if (hold_req) begin
          hold_req = 1'b0;
          match_ch.ready <= 1'b0;
          repeat (HOLD_CYCLES) @(posedge clk);
        end
        case (mode)
          0: match_ch.ready <= 1'b1;
          1: match_ch.ready <= ($urandom_range(0, 3) != 0);
          2: match_ch.ready <= ($urandom_range(0, 3) == 0);
          default: match_ch.ready <= ~match_ch.ready;
        endcase
      end
    end
  end

  function automatic logic [CFG_W-1:0] rand_word();
    return CFG_W'({$urandom, $urandom});
  endfunction

  // Offer one note and wait for it to be taken; idle between bursts
  task automatic send_note(input note_t v);
    int gap;
    note_ch.valid      <= 1'b1;
    note_ch.note_value <= v;
    do @(posedge clk); while (!note_ch.ready);
    notes_sent++;
    burst_left--;
    if (burst_left <= 0 && !steady) begin
      gap = $urandom_range(1, 12);
      note_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
      burst_left = $urandom_range(1, 40);
    end
  endtask

  task automatic write_reg(input cfg_index_t idx, input logic [CFG_W-1:0] v);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= v;
    @(posedge clk);
  endtask

  task automatic load_templates(input logic [CFG_W-1:0] count_v,
                                input logic [CFG_W-1:0] lens_v,
                                input logic [CFG_W-1:0] a_v,
                                input logic [CFG_W-1:0] b_v,
                                input logic [CFG_W-1:0] c_v);
    cur_lens     = lens_v[LENS_W-1:0];
    cur_notes[0] = a_v;
    cur_notes[1] = b_v;
    cur_notes[2] = c_v;
    write_reg(CFG_TEMPLATE_COUNT, count_v);
    write_reg(CFG_TEMPLATE_LENGTHS, lens_v);
    write_reg(CFG_NOTES_A, a_v);
    write_reg(CFG_NOTES_B, b_v);
    write_reg(CFG_NOTES_C, c_v);
    cfg_we <= 1'b0;
  endtask

  // Stop offering and wait until every result is back
  task automatic drain_results();
    note_ch.valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (3) @(posedge clk);
  endtask

  initial begin : stimulus
    logic [CFG_W-1:0]  count_v;
    logic [LENS_W-1:0] lens;
    logic [CFG_W-1:0]  tmpl [MAX_SLOTS];
    note_t             n;
    int                r;
    int                slot;
    int                len;
    int                bad;
    int                v;
    int                off;
    int                target;

    note_ch.valid      <= 1'b0;
    note_ch.note_value <= '0;
    cfg_we             <= 1'b0;
    cfg_index          <= CFG_TEMPLATE_COUNT;
    cfg_data           <= '0;
    rst                <= 1'b1;
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    // No slots searched after reset
    send_note(note_t'(0));
    send_note(note_t'(127));
    drain_results();

    // Short templates: within one bin, two bins off, empty template last
    load_templates(CFG_W'(3), CFG_W'(12'h013),
                   (CFG_W'(30) << 14) | (CFG_W'(20) << 7) | CFG_W'(10),
                   CFG_W'(127), '0);
    send_note(note_t'(10));
    send_note(note_t'(21));
    send_note(note_t'(29));
    send_note(note_t'(126));
    send_note(note_t'(5));
    send_note(note_t'(10));
    send_note(note_t'(22));
    send_note(note_t'(29));
    drain_results();

    // Oversized lengths saturate to eight, extra register bits ignored
    load_templates('1, '1, '1, '0, rand_word());
    repeat (8) send_note(note_t'(127));
    repeat (8) send_note(note_t'(0));
    drain_results();

    // Random phases
    for (int p = 0; p < PHASES; p++) begin
      r = $urandom_range(0, 3);
      count_v = (rand_word() << COUNT_W) |
                CFG_W'((r == 0) ? $urandom_range(0, 2) : 3);
      for (int s = 0; s < MAX_SLOTS; s++) begin
        r = $urandom_range(0, 9);
        if (r == 0)      lens[s*LEN_W +: LEN_W] = '0;
        else if (r == 1) lens[s*LEN_W +: LEN_W] = LEN_W'($urandom_range(9, 15));
        else             lens[s*LEN_W +: LEN_W] = LEN_W'($urandom_range(1, 8));
        for (int j = 0; j < NOTES; j++) begin
          r = $urandom_range(0, 7);
          if (r == 0)      tmpl[s][j*NOTE_W +: NOTE_W] = '0;
          else if (r == 1) tmpl[s][j*NOTE_W +: NOTE_W] = '1;
          else             tmpl[s][j*NOTE_W +: NOTE_W] = NOTE_W'($urandom_range(0, 127));
        end
      end
      load_templates(count_v, (rand_word() << LENS_W) | CFG_W'(lens),
                     tmpl[0], tmpl[1], tmpl[2]);
      target = notes_sent + PHASE_NOTES;

      // Long receiver hold-off while notes keep coming
      if (p == 0) begin
        hold_req = 1'b1;
        steady   = 1'b1;
        repeat (20) send_note(note_t'($urandom_range(0, 127)));
        steady     = 1'b0;
        burst_left = 1;
      end

      while (notes_sent < target) begin
        r = $urandom_range(0, 9);
        if (r < 7) begin
          // Sequence following one template, jittered; sometimes broken
          slot = $urandom_range(0, MAX_SLOTS - 1);
          len  = int'(cur_lens[slot*LEN_W +: LEN_W]);
          if (len > NOTES) len = NOTES;
          bad  = (r == 6) ? $urandom_range(0, NOTES - 1) : NOTES;
          for (int j = 0; j < len; j++) begin
            v = int'(cur_notes[slot][j*NOTE_W +: NOTE_W]);
            if (j == bad) begin
              off = int'($urandom_range(2, 6));
              if ($urandom_range(0, 1) != 0) off = -off;
              v = v + off;
            end else begin
              v = v + int'($urandom_range(0, 2)) - 1;
              if (v < 0) v = 0;
              if (v > 127) v = 127;
            end
            n = note_t'(v);
            send_note(n);
          end
        end else begin
          // Noise
          repeat ($urandom_range(1, 4)) send_note(note_t'($urandom_range(0, 127)));
        end
      end
      drain_results();
    end

    if (fail_count == 0)
      $display("note_sequence_template_matcher_top regression: pass");
    else
      $display("note_sequence_template_matcher_top regression: fail");
    $finish;
  end

endmodule
